[rtl/lmx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmx_pkg
// Shared types and constants of the Lamport mutual exclusion node: command
// codes passed from the front end to the executor, result actions, register
// indexes and the executor state type.
// ----------------------------------------------------------------------------
package lmx_pkg;

  localparam int TIME_BITS = 32;
  localparam int NODE_BITS = 3;
  localparam int CNT_BITS  = 4;
  localparam int OWED_BITS = 3;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Command queue between front end and executor.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration register indexes.
  localparam logic CFG_OWN_NODE   = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  // Input selector codes.
  localparam logic       OP_LOCAL  = 1'b0;
  localparam logic       OP_MSG    = 1'b1;
  localparam logic [1:0] MSG_REQ   = 2'd0;
  localparam logic [1:0] MSG_REPLY = 2'd1;
  localparam logic [1:0] MSG_DONE  = 2'd2;

  typedef enum logic [2:0] {
    CMD_LOCAL,
    CMD_REQ,
    CMD_REPLY,
    CMD_DONE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [NODE_BITS-1:0] node;
    logic                 in_range;
    logic [TIME_BITS-1:0] time_v;
  } lmx_cmd_t;

  typedef enum logic [2:0] {
    ACT_REQUEST = 3'd0,
    ACT_REPLY   = 3'd1,
    ACT_GRANT   = 3'd2,
    ACT_DONE    = 3'd3,
    ACT_REJECT  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_RDOWN,
    B_SCAN,
    B_EMIT1,
    B_GRANT,
    B_DONE
  } bstate_t;

endpackage : lmx_pkg
`default_nettype wire

[rtl/lmx_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmx_front
// Front end: unpacks an incoming request, classifies it into an executor
// command and pushes it into the command queue.
// ----------------------------------------------------------------------------
module lmx_front #(
  parameter int MAX_NODES = 8
) (
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,
  input  wire logic [2:0]        in_tuser,
  input  wire logic              q_full,
  output logic                   q_push,
  output lmx_pkg::lmx_cmd_t      q_wr_cmd
);
  import lmx_pkg::*;

  logic                 opcode;
  logic [1:0]           msg_kind;
  logic [NODE_BITS-1:0] msg_node;
  logic [TIME_BITS-1:0] msg_time;

  assign opcode   = in_tuser[0];
  assign msg_kind = in_tuser[2:1];
  assign msg_node = in_tdata[NODE_BITS-1:0];
  assign msg_time = in_tdata[NODE_BITS+TIME_BITS-1:NODE_BITS];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wr_cmd.node     = msg_node;
    q_wr_cmd.time_v   = msg_time;
    q_wr_cmd.in_range = 32'(msg_node) < 32'(MAX_NODES);
    if (opcode == OP_LOCAL) begin
      q_wr_cmd.kind = CMD_LOCAL;
    end else begin
      case (msg_kind)
        MSG_REQ:   q_wr_cmd.kind = CMD_REQ;
        MSG_REPLY: q_wr_cmd.kind = CMD_REPLY;
        MSG_DONE:  q_wr_cmd.kind = CMD_DONE;
        default:   q_wr_cmd.kind = CMD_NOP;
      endcase
    end
  end

endmodule : lmx_front
`default_nettype wire

[rtl/lmx_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmx_queue
// Two-entry command queue that decouples the front end from the executor.
// ----------------------------------------------------------------------------
module lmx_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lmx_pkg::lmx_cmd_t wr_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output lmx_pkg::lmx_cmd_t      head
);
  import lmx_pkg::*;

  lmx_cmd_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = count_r == QCNT_W'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule : lmx_queue
`default_nettype wire

[rtl/lmx_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmx_back
// Executor: holds the logical clock, request slots and own request, carries
// out one command, scans the slots for the oldest request and sends the
// results through an output register.
// ----------------------------------------------------------------------------
module lmx_back #(
  parameter int MAX_NODES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire lmx_pkg::lmx_cmd_t q_head,
  output logic                   q_pop,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [3:0]        cfg_data,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);
  import lmx_pkg::*;

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  bstate_t state_r, state_nxt;

  // Configuration.
  logic [NODE_BITS-1:0] own_node_r;
  logic [CNT_BITS-1:0]  node_count_r;

  // Protocol state.
  logic [TIME_BITS-1:0] clock_r;
  logic                 pending_r;
  logic [TIME_BITS-1:0] own_time_r;
  logic [OWED_BITS-1:0] owed_r;
  logic                 valid_r [MAX_NODES];
  logic [TIME_BITS-1:0] slot_time [MAX_NODES];

  // Work registers.
  lmx_cmd_t             cmd_r;
  logic [TIME_BITS-1:0] rd_data_r;
  logic [TIME_BITS-1:0] own_t_r;
  logic [IDX_W:0]       sc_r;
  logic                 blocked_r;
  logic                 grant_r;
  logic                 has_first_r;
  action_t              first_act_r;
  logic [NODE_BITS-1:0] first_dest_r;
  logic [TIME_BITS-1:0] first_time_r;

  // Output register.
  logic                 out_valid_r;
  action_t              out_act_r;
  logic [NODE_BITS-1:0] out_dest_r;
  logic [TIME_BITS-1:0] out_time_r;
  logic                 out_last_r;

  // Combinational helpers.
  logic [IDX_W-1:0]     own_idx, cmd_idx, jidx, rd_addr;
  logic                 own_in_range, own_valid;
  logic [TIME_BITS-1:0] clk_max, clk_new;
  logic [CNT_BITS-1:0]  nc_m1;
  logic [OWED_BITS-1:0] owed_init;
  logic                 hit_now, grant_now, scan_end, out_free, out_load;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;
  action_t              ld_act;
  logic [NODE_BITS-1:0] ld_dest;
  logic [TIME_BITS-1:0] ld_time;
  logic                 ld_last;
  logic                 cmd_other;

  assign own_idx      = IDX_W'(own_node_r);
  assign own_in_range = 32'(own_node_r) < 32'(MAX_NODES);
  assign own_valid    = own_in_range && valid_r[own_idx];
  assign cmd_idx      = IDX_W'(cmd_r.node);
  assign cmd_other    = cmd_r.node != own_node_r;
  assign jidx         = IDX_W'(sc_r - 1'b1);
  assign scan_end     = sc_r == (IDX_W+1)'(MAX_NODES);

  assign clk_max = (clock_r > cmd_r.time_v) ? clock_r : cmd_r.time_v;
  assign clk_new = (clk_max == TIME_MAX) ? clk_max : clk_max + 1'b1;

  assign nc_m1     = node_count_r - 1'b1;
  assign owed_init = (node_count_r == '0) ? '0 :
                     (nc_m1 > CNT_BITS'(7)) ? '1 : nc_m1[OWED_BITS-1:0];

  // Slot j (one behind the read address) beats our own request.
  assign hit_now = (sc_r != '0) && (jidx != own_idx) && valid_r[jidx] &&
                   ((rd_data_r < own_t_r) ||
                    ((rd_data_r == own_t_r) && (jidx < own_idx)));
  assign grant_now = pending_r && (owed_r == '0) && own_valid &&
                     !blocked_r && !hit_now;

  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_time_r, own_node_r, out_dest_r};

  // Next state and strobes.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    rd_addr   = IDX_W'(q_head.node);
    ld_act    = first_act_r;
    ld_dest   = first_dest_r;
    ld_time   = first_time_r;
    ld_last   = !grant_r;
    mem_we    = 1'b0;
    mem_waddr = own_idx;
    mem_wdata = clock_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cmd_r.kind == CMD_LOCAL && pending_r) begin
          state_nxt = B_EMIT1;
        end else begin
          state_nxt = B_RDOWN;
        end
        if (cmd_r.kind == CMD_LOCAL && !pending_r && own_in_range) begin
          mem_we = 1'b1;
        end else if (cmd_r.kind == CMD_REQ && cmd_other && cmd_r.in_range) begin
          mem_we    = 1'b1;
          mem_waddr = cmd_idx;
          mem_wdata = cmd_r.time_v;
        end
      end
      B_RDOWN: begin
        rd_addr   = own_idx;
        state_nxt = B_SCAN;
      end
      B_SCAN: begin
        rd_addr = sc_r[IDX_W-1:0];
        if (scan_end) begin
          if (has_first_r) begin
            state_nxt = B_EMIT1;
          end else if (grant_now) begin
            state_nxt = B_GRANT;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_EMIT1: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = grant_r ? B_GRANT : B_IDLE;
        end
      end
      B_GRANT: begin
        ld_act  = ACT_GRANT;
        ld_dest = '0;
        ld_time = own_time_r;
        ld_last = 1'b0;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        ld_act  = ACT_DONE;
        ld_dest = '0;
        ld_time = own_time_r;
        ld_last = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      own_node_r   <= '0;
      node_count_r <= CNT_BITS'(6);
      clock_r      <= '0;
      pending_r    <= 1'b0;
      own_time_r   <= '0;
      owed_r       <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        valid_r[i] <= 1'b0;
      end
      sc_r         <= '0;
      blocked_r    <= 1'b0;
      grant_r      <= 1'b0;
      has_first_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_OWN_NODE:   own_node_r   <= cfg_data[NODE_BITS-1:0];
          CFG_NODE_COUNT: node_count_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        B_EXEC: begin
          sc_r        <= '0;
          blocked_r   <= 1'b0;
          grant_r     <= 1'b0;
          has_first_r <= (cmd_r.kind == CMD_LOCAL) || (cmd_r.kind == CMD_REQ);
          case (cmd_r.kind)
            CMD_LOCAL: begin
              if (!pending_r) begin
                pending_r  <= 1'b1;
                own_time_r <= clock_r;
                owed_r     <= owed_init;
                if (own_in_range) begin
                  valid_r[own_idx] <= 1'b1;
                end
              end
            end
            CMD_REQ: begin
              clock_r <= clk_new;
              if (cmd_other && cmd_r.in_range) begin
                valid_r[cmd_idx] <= 1'b1;
              end
            end
            CMD_REPLY: begin
              clock_r <= clk_new;
              if (owed_r != '0) begin
                owed_r <= owed_r - 1'b1;
              end
            end
            CMD_DONE: begin
              clock_r <= clk_new;
              if (cmd_other && cmd_r.in_range && valid_r[cmd_idx] &&
                  rd_data_r == cmd_r.time_v) begin
                valid_r[cmd_idx] <= 1'b0;
              end
            end
            default: clock_r <= clk_new;
          endcase
        end
        B_SCAN: begin
          sc_r <= sc_r + 1'b1;
          if (hit_now) begin
            blocked_r <= 1'b1;
          end
          if (scan_end) begin
            grant_r <= grant_now;
          end
        end
        B_GRANT: begin
          if (out_free) begin
            pending_r <= 1'b0;
            if (own_in_range) begin
              valid_r[own_idx] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Slot timestamp memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_time[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_time[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (state_r == B_SCAN && sc_r == '0) begin
      own_t_r <= rd_data_r;
    end
    if (state_r == B_EXEC) begin
      case (cmd_r.kind)
        CMD_LOCAL: begin
          first_act_r  <= pending_r ? ACT_REJECT : ACT_REQUEST;
          first_dest_r <= '0;
          first_time_r <= clock_r;
        end
        CMD_REQ: begin
          first_act_r  <= ACT_REPLY;
          first_dest_r <= cmd_r.node;
          first_time_r <= clk_new;
        end
        default: begin
          first_act_r  <= ACT_REPLY;
          first_dest_r <= '0;
          first_time_r <= clock_r;
        end
      endcase
    end
    if (out_load) begin
      out_act_r  <= ld_act;
      out_dest_r <= ld_dest;
      out_time_r <= ld_time;
      out_last_r <= ld_last;
    end
  end

endmodule : lmx_back
`default_nettype wire

[rtl/lamport_mutex_node.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lamport_mutex_node
// One participant of Lamport distributed mutual exclusion: a logical clock,
// one request slot per node and the node's own pending request.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Carries
//  in_      in   in_tvalid/in_tready  one request: local wish or message
//  out_     out  out_tvalid/tready    zero to three results per request
//  cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// A rejected duplicate skips the slot scan; every other request passes
// through the scan, which reads one timestamp per cycle from the slot
// memory, before its results go out.
// Reset (rst_n low at a clock edge) clears the clock, the slot valid bits,
// the pending request and the queue; own_node returns to 0, node_count to 6.
// A stalled output holds the executor; the two-entry queue keeps taking
// requests until it is full, so in_tready drops only then.
//
module lamport_mutex_node #(
  parameter int MAX_NODES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // msg_node[2:0], msg_time[34:3], zero
  input  wire logic [2:0]  in_tuser,   // opcode[0], msg_kind[2:1]
  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // dest_node[2:0], out_node[5:3],
                                       // out_time[37:6], zero
  output logic [2:0]       out_tuser,  // action[2:0]
  output logic             out_tlast,  // last result of this request
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,  // 0 own_node, 1 node_count
  input  wire logic [3:0]  cfg_data
);
  import lmx_pkg::*;

  lmx_cmd_t wr_cmd;
  lmx_cmd_t head;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     head_valid;

  // Front end: classify each request and queue it.
  lmx_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wr_cmd  (wr_cmd)
  );

  lmx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_cmd     (wr_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Executor: protocol state, slot scan and result sequencing.
  lmx_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_head     (head),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule : lamport_mutex_node
`default_nettype wire

[tb/lamport_mutex_node_checker.sv]
// ----------------------------------------------------------------------------
// lamport_mutex_node_checker
// Watches the request, result and register channels of the mutex node, keeps
// its own copy of the node state, predicts the actions each request causes
// and compares every result with the oldest predicted action.
// ----------------------------------------------------------------------------
module lamport_mutex_node_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,   // msg_node[2:0], msg_time[34:3], zero
  input  wire logic [2:0]  in_tuser,   // opcode[0], msg_kind[2:1]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,  // dest_node[2:0], out_node[5:3],
                                       // out_time[37:6], zero
  input  wire logic [2:0]  out_tuser,  // action[2:0]
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  output int               fail_count,
  output int               actions_due
);
  import lmx_pkg::*;

  typedef struct {
    action_t              act;
    logic [NODE_BITS-1:0] dest;
    logic [NODE_BITS-1:0] node;
    logic [TIME_BITS-1:0] stamp;
    logic                 last;
  } node_action_t;

  // Predicted node state and registers.
  logic [NODE_BITS-1:0] own_id;
  logic [CNT_BITS-1:0]  node_total;
  logic [TIME_BITS-1:0] clock_now;
  logic                 req_pending;
  logic [TIME_BITS-1:0] own_stamp;
  logic [OWED_BITS-1:0] owed;
  logic [7:0]           slot_v;
  logic [TIME_BITS-1:0] slot_t [8];

  node_action_t action_q [$];

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // The own slot leads when no other valid slot holds a smaller (time, node).
  function automatic logic own_leads();
    logic lead;
    lead = slot_v[own_id];
    for (int j = 0; j < 8; j++) begin
      if (j != own_id && slot_v[j] &&
          (slot_t[j] < slot_t[own_id] || (slot_t[j] == slot_t[own_id] && j < own_id)))
        lead = 1'b0;
    end
    return lead;
  endfunction

  task automatic predict_actions(logic op, logic [1:0] kind, logic [NODE_BITS-1:0] node,
                                 logic [TIME_BITS-1:0] stamp);
    node_action_t res [3];
    int n;
    logic [TIME_BITS-1:0] hi;
    n = 0;
    if (op == OP_LOCAL && req_pending) begin
      res[0] = '{ACT_REJECT, '0, own_id, clock_now, 1'b0};
      n = 1;
    end else begin
      if (op == OP_LOCAL) begin
        req_pending = 1'b1;
        own_stamp = clock_now;
        if (node_total == 0)
          owed = '0;
        else if (node_total > 8)
          owed = 3'd7;
        else
          owed = 3'(node_total - 1);
        slot_v[own_id] = 1'b1;
        slot_t[own_id] = clock_now;
        res[n++] = '{ACT_REQUEST, '0, own_id, clock_now, 1'b0};
      end else begin
        hi = (clock_now > stamp) ? clock_now : stamp;
        clock_now = (hi == TIME_MAX) ? TIME_MAX : hi + 1;
        case (kind)
          MSG_REQ: begin
            if (node != own_id) begin
              slot_v[node] = 1'b1;
              slot_t[node] = stamp;
            end
            res[n++] = '{ACT_REPLY, node, own_id, clock_now, 1'b0};
          end
          MSG_REPLY: begin
            if (owed != 0)
              owed--;
          end
          MSG_DONE: begin
            if (node != own_id && slot_v[node] && slot_t[node] == stamp)
              slot_v[node] = 1'b0;
          end
          default: ;
        endcase
      end
      if (req_pending && owed == 0 && own_leads()) begin
        res[n++] = '{ACT_GRANT, '0, own_id, own_stamp, 1'b0};
        slot_v[own_id] = 1'b0;
        req_pending = 1'b0;
        res[n++] = '{ACT_DONE, '0, own_id, own_stamp, 1'b0};
      end
    end
    if (n > 0)
      res[n-1].last = 1'b1;
    for (int k = 0; k < n; k++)
      action_q.insert(action_q.size(), res[k]);
  endtask

  always @(posedge clk) begin
    node_action_t want;
    if (!rst_n) begin
      own_id      = '0;
      node_total  = 4'd6;
      clock_now   = '0;
      req_pending = 1'b0;
      own_stamp   = '0;
      owed        = '0;
      slot_v      = '0;
      for (int j = 0; j < 8; j++)
        slot_t[j] = '0;
      action_q.delete();
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OWN_NODE)
          own_id = cfg_data[2:0];
        else
          node_total = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (action_q.size() == 0) begin
          flag_mismatch("result with nothing expected, action", 32'(out_tuser), 0);
        end else begin
          want = action_q.pop_front();
          if (out_tuser != want.act)
            flag_mismatch("action", 32'(out_tuser), 32'(want.act));
          if (out_tdata[2:0] != want.dest)
            flag_mismatch("dest_node", 32'(out_tdata[2:0]), 32'(want.dest));
          if (out_tdata[5:3] != want.node)
            flag_mismatch("out_node", 32'(out_tdata[5:3]), 32'(want.node));
          if (out_tdata[37:6] != want.stamp)
            flag_mismatch("out_time", out_tdata[37:6], want.stamp);
          if (out_tlast != want.last)
            flag_mismatch("last", 32'(out_tlast), 32'(want.last));
        end
      end
      if (in_tvalid && in_tready)
        predict_actions(in_tuser[0], in_tuser[2:1], in_tdata[2:0], in_tdata[34:3]);
    end
    actions_due <= action_q.size();
  end

endmodule

[tb/lamport_mutex_node_tb.sv]
// ----------------------------------------------------------------------------
// lamport_mutex_node_tb
// Drives the mutex node with directed cases and then with well-formed
// request rounds (wish, replies, remote requests and releases) under several
// register settings, with random stalls on both channels. A checker module
// beside the node predicts and compares every result.
// ----------------------------------------------------------------------------
module lamport_mutex_node_tb;
  import lmx_pkg::*;

  // Cycles to let the node drain requests that cause no result before a
  // register write or the verdict, with up to three requests in flight.
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 300000;
  localparam logic [1:0] MSG_UNKNOWN = 2'd3;
  localparam int PHASE_ITEMS   = 50;

  // Register settings per random phase, four bits each, phase 0 lowest.
  // The last phase uses timestamps across the whole range and drives the
  // clock into saturation, so it must stay last.
  localparam logic [31:0] PHASE_OWN   = {4'd7, 4'd4, 4'd1, 4'd6, 4'd2, 4'd5, 4'd7, 4'd0};
  localparam logic [31:0] PHASE_COUNT = {4'd5, 4'd9, 4'd3, 4'd15, 4'd0, 4'd1, 4'd8, 4'd2};
  localparam int CALM_PHASE = 2;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // msg_node[2:0], msg_time[34:3], zero
  logic [2:0]  in_tuser;   // opcode[0], msg_kind[2:1]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // dest_node[2:0], out_node[5:3], out_time[37:6], zero
  logic [2:0]  out_tuser;  // action[2:0]
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [3:0]  cfg_data;

  int fail_count;
  int actions_due;
  int cycle_count = 0;
  int items_sent  = 0;

  // While calm is set neither side inserts idle cycles.
  bit calm = 1'b0;

  // Stimulus-side view of the node: the registers as last written, the
  // logical clock (exactly known, since only messages move it) and the remote
  // slots this side has filled and not yet released.
  logic [2:0]  cur_own   = 3'd0;
  logic [3:0]  cur_count = 4'd6;
  logic [31:0] clk_est   = '0;
  logic [7:0]  held_v    = '0;
  logic [31:0] held_t [8];

  lamport_mutex_node u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lamport_mutex_node_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .actions_due (actions_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result side stalls on its own schedule, independent of the stimulus.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 38);
  end

  // A hung handshake or a prediction that never arrives ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one request and returns at the edge that accepts it, with valid
  // still high so that a following request can go out without a gap.
  task automatic push_request(logic op, logic [1:0] kind, logic [2:0] node,
                              logic [31:0] stamp);
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, stamp, node};
    in_tuser  <= {kind, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // A local wish; the message fields carry junk, which the node ignores.
  task automatic send_wish();
    push_request(OP_LOCAL, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic send_msg(logic [1:0] kind, logic [2:0] node, logic [31:0] stamp);
    logic [31:0] hi;
    push_request(OP_MSG, kind, node, stamp);
    hi = (clk_est > stamp) ? clk_est : stamp;
    clk_est = (hi == TIME_MAX) ? TIME_MAX : hi + 1;
    if (node != cur_own) begin
      if (kind == MSG_REQ) begin
        held_v[node] = 1'b1;
        held_t[node] = stamp;
      end else if (kind == MSG_DONE && held_v[node] && held_t[node] == stamp) begin
        held_v[node] = 1'b0;
      end
    end
  endtask

  // Register writes only happen with the node idle: input stopped, every
  // predicted action delivered, and time for result-free requests to drain.
  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (actions_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_OWN_NODE)
      cur_own = val[2:0];
    else
      cur_count = val;
  endtask

  function automatic logic [2:0] other_node();
    logic [2:0] n;
    n = 3'($urandom_range(0, 6));
    if (n >= cur_own)
      n++;
    return n;
  endfunction

  // Any remote slot still held, starting the search at a random node.
  function automatic int held_slot();
    int start;
    start = $urandom_range(0, 7);
    for (int k = 0; k < 8; k++) begin
      if (held_v[(start + k) % 8])
        return (start + k) % 8;
    end
    return -1;
  endfunction

  // Timestamps close to the clock give ties and both orderings against the
  // own request; the wide form covers every bit and the saturation point.
  function automatic logic [31:0] pick_time(bit wide);
    int off;
    if (wide) begin
      case ($urandom_range(0, 4))
        0:       return TIME_MAX;
        1:       return TIME_MAX - 1;
        2:       return clk_est;
        default: return $urandom;
      endcase
    end
    off = $urandom_range(0, 8);
    return (clk_est > 4) ? clk_est - 4 + off : 32'(off);
  endfunction

  // One round of the protocol: the node asks for the critical section, the
  // peers reply, and every remote request it has seen is eventually
  // released, so the round always ends with the grant and no request left
  // pending. Noise messages are mixed in along the way.
  task automatic play_round(bit wide);
    int owed;
    int fresh;
    int j;
    int r;
    if (cur_count == 0)
      owed = 0;
    else if (cur_count > 8)
      owed = 7;
    else
      owed = cur_count - 1;
    fresh = 0;
    repeat ($urandom_range(0, 2)) send_msg(MSG_REQ, other_node(), pick_time(wide));
    send_wish();
    if ($urandom_range(0, 7) == 0)
      send_wish();
    while (owed > 0 || held_slot() >= 0) begin
      r = $urandom_range(0, 99);
      j = held_slot();
      if (r < 40 && owed > 0) begin
        send_msg(MSG_REPLY, other_node(), pick_time(wide));
        owed--;
      end else if (r < 55 && fresh < 6) begin
        send_msg(MSG_REQ, other_node(), pick_time(wide));
        fresh++;
      end else if (r < 80 && j >= 0) begin
        send_msg(MSG_DONE, j[2:0], held_t[j]);
      end else begin
        case ($urandom_range(0, 4))
          0:       send_msg(MSG_UNKNOWN, 3'($urandom_range(0, 7)), pick_time(wide));
          1:       send_msg(MSG_DONE, other_node(), pick_time(wide));
          2:       send_msg(MSG_REQ, cur_own, pick_time(wide));
          3:       send_msg(MSG_DONE, cur_own, pick_time(wide));
          default: send_msg(MSG_REPLY, other_node(), pick_time(wide));
        endcase
      end
    end
  endtask

  initial begin
    logic [31:0] c;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: node 3 of four, so three replies are owed per request.
    write_reg(CFG_OWN_NODE, 4'd3);
    write_reg(CFG_NODE_COUNT, 4'd4);
    send_msg(MSG_DONE, 3'd5, 32'd0);      // release of an empty slot
    send_msg(MSG_REPLY, 3'd1, 32'd0);     // reply while none is owed
    send_msg(MSG_UNKNOWN, 3'd6, 32'd7);   // unknown kind only moves the clock
    send_msg(MSG_REQ, 3'd7, 32'd0);       // highest node, oldest time
    send_msg(MSG_REQ, 3'd3, 32'd2);       // request naming this node
    send_msg(MSG_DONE, 3'd3, 32'd2);      // release naming this node
    send_wish();
    send_wish();                          // duplicate wish is rejected
    send_msg(MSG_REPLY, 3'd0, clk_est);
    send_msg(MSG_REPLY, 3'd2, clk_est);
    send_msg(MSG_REPLY, 3'd4, clk_est);   // all replies in, node 7 still older
    send_msg(MSG_DONE, 3'd7, 32'd5);      // release with the wrong time
    send_msg(MSG_DONE, 3'd7, 32'd0);      // real release: grant and done follow
    // Equal timestamps: node 0 wins the tie over this node, node 7 loses it.
    c = clk_est;
    send_wish();
    send_msg(MSG_REQ, 3'd7, c);
    send_msg(MSG_REQ, 3'd0, c);
    send_msg(MSG_REPLY, 3'd1, clk_est);
    send_msg(MSG_REPLY, 3'd2, clk_est);
    send_msg(MSG_REPLY, 3'd5, clk_est);
    send_msg(MSG_DONE, 3'd0, c);
    send_msg(MSG_DONE, 3'd7, c);

    // Random rounds under each register setting; one phase runs without
    // any idle cycles on either side.
    for (int p = 0; p < 8; p++) begin
      int goal;
      write_reg(CFG_OWN_NODE, PHASE_OWN[p*4 +: 4]);
      write_reg(CFG_NODE_COUNT, PHASE_COUNT[p*4 +: 4]);
      calm = (p == CALM_PHASE);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal)
        play_round(p == 7);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (actions_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
